FILE: hdl/pss_pkg.sv
// Shared types, codes and helpers for the PLL start-up sequencer.
package pss_pkg;

  // Width of the wrapping event counters.
  localparam int COUNT_WIDTH = 32;
  typedef logic [COUNT_WIDTH-1:0] count_t;

  // Sequencer phase codes.
  localparam logic [3:0] PH_DISABLED     = 4'd0;
  localparam logic [3:0] PH_CLEAR        = 4'd1;
  localparam logic [3:0] PH_WAIT_CLEAR   = 4'd2;
  localparam logic [3:0] PH_START_EXT    = 4'd3;
  localparam logic [3:0] PH_WAIT_EXT     = 4'd4;
  localparam logic [3:0] PH_START_HELPER = 4'd5;
  localparam logic [3:0] PH_WAIT_HELPER  = 4'd6;
  localparam logic [3:0] PH_START_MAIN   = 4'd7;
  localparam logic [3:0] PH_WAIT_MAIN    = 4'd8;
  localparam logic [3:0] PH_READY        = 4'd9;

  // Operating modes.
  localparam logic [1:0] MODE_DISABLED = 2'd0;
  localparam logic [1:0] MODE_GM       = 2'd1;
  localparam logic [1:0] MODE_MASTER   = 2'd2;
  localparam logic [1:0] MODE_SLAVE    = 2'd3;

  // Tagger control codes.
  localparam logic [1:0] TAGGER_KEEP    = 2'd0;
  localparam logic [1:0] TAGGER_ENABLE  = 2'd1;
  localparam logic [1:0] TAGGER_DISABLE = 2'd2;

  // Reference channel status events.
  localparam logic [1:0] STATUS_NONE   = 2'd0;
  localparam logic [1:0] STATUS_LOCKED = 2'd1;
  localparam logic [1:0] STATUS_CLEAR  = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] CFG_MODE           = 3'd0;
  localparam logic [2:0] CFG_N_REF_CHANNELS = 3'd1;
  localparam logic [2:0] CFG_SETTLE_TICKS   = 3'd2;
  localparam logic [2:0] CFG_HELPER_DAC_MAX = 3'd3;
  localparam logic [2:0] CFG_MAIN_DAC_MIN   = 3'd4;
  localparam logic [2:0] CFG_MAIN_DAC_MAX   = 3'd5;

  // Reset value of the settling wait.
  localparam logic [31:0] SETTLE_TICKS_RESET = 32'd3125000;

  // One phase-tag event.
  typedef struct packed {
    logic [3:0]  source_index;
    logic [31:0] now_ticks;
    logic        helper_locked;
    logic        helper_lock_changed;
    logic        main_locked;
    logic        ext_locked;
  } tag_item_t;

  // One result of the sequencer.
  typedef struct packed {
    logic [3:0]  sequence_phase;
    logic        clear_dacs;
    logic [15:0] main_dac_mid;
    logic [1:0]  tagger_ctrl;
    logic        start_ext;
    logic        start_helper;
    logic        start_main;
    logic        start_trackers;
    logic [1:0]  status_event;
    logic [31:0] delock_total;
    logic [31:0] osc_tag_total;
    logic [31:0] ref_tag_total;
  } res_item_t;

  // Register values and restart request handed to the core.
  typedef struct packed {
    logic        restart;
    logic [1:0]  restart_mode;
    logic [1:0]  mode;
    logic [3:0]  n_ref_channels;
    logic [31:0] settle_ticks;
    logic [15:0] main_dac_min;
    logic [15:0] main_dac_max;
  } cfg_t;

  // Low 32 bits of a counter, zero-extended when the counter is narrower.
  function automatic logic [31:0] count_to_32(input count_t c);
    logic [COUNT_WIDTH+31:0] ext;
    ext = {32'd0, c};
    return ext[31:0];
  endfunction

endpackage

FILE: hdl/pss_cfg.sv
// Configuration registers of the PLL start-up sequencer.
module pss_cfg (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  input  logic [2:0]      wr_index,
  input  logic [31:0]     wr_data,
  output pss_pkg::cfg_t   cfg
);
  import pss_pkg::*;

  logic [1:0]  mode;
  logic [3:0]  n_ref_channels;
  logic [31:0] settle_ticks;
  logic [15:0] main_dac_min;
  logic [15:0] main_dac_max;
  logic        restart;

  // A mode write restarts the sequencer at the same edge that takes the write.
  assign restart = wr_en && (wr_index == CFG_MODE);

  // Register writes.
  // The helper DAC maximum write is accepted but its value is not kept.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_DISABLED;
      n_ref_channels <= 4'd1;
      settle_ticks   <= SETTLE_TICKS_RESET;
      main_dac_min   <= 16'd0;
      main_dac_max   <= 16'hFFFF;
    end else begin
      if (wr_en) begin
        unique case (wr_index)
          CFG_MODE:           mode           <= wr_data[1:0];
          CFG_N_REF_CHANNELS: n_ref_channels <= wr_data[3:0];
          CFG_SETTLE_TICKS:   settle_ticks   <= wr_data;
          CFG_HELPER_DAC_MAX: ;
          CFG_MAIN_DAC_MIN:   main_dac_min   <= wr_data[15:0];
          CFG_MAIN_DAC_MAX:   main_dac_max   <= wr_data[15:0];
          default: ;
        endcase
      end
    end
  end

  assign cfg.restart        = restart;
  assign cfg.restart_mode   = wr_data[1:0];
  assign cfg.mode           = mode;
  assign cfg.n_ref_channels = n_ref_channels;
  assign cfg.settle_ticks   = settle_ticks;
  assign cfg.main_dac_min   = main_dac_min;
  assign cfg.main_dac_max   = main_dac_max;

endmodule

FILE: hdl/pss_core.sv
// Sequencer state, tag counters and result formation for one tag event.
module pss_core (
  input  logic                clk,
  input  logic                rst,
  input  pss_pkg::cfg_t       cfg,
  input  logic                accept,
  input  pss_pkg::tag_item_t  tag,
  output pss_pkg::res_item_t  res,
  output logic [3:0]          phase
);
  import pss_pkg::*;

  logic [31:0] settle_deadline;
  count_t      delock_counter;
  count_t      osc_tag_counter;
  count_t      ref_tag_counter;

  logic [3:0]  phase_next;
  logic [31:0] settle_deadline_next;
  count_t      delock_counter_next;
  count_t      osc_tag_counter_next;
  count_t      ref_tag_counter_next;

  logic [16:0] dac_sum;
  logic [31:0] deadline_diff;
  logic        clr, sx, sh, sm, st;
  logic [1:0]  tagger, ev;
  logic        delocked;

  assign dac_sum       = {1'b0, cfg.main_dac_min} + {1'b0, cfg.main_dac_max};
  assign deadline_diff = settle_deadline - tag.now_ticks;
  assign delocked      = (cfg.mode == MODE_GM && !tag.ext_locked) || !tag.helper_locked ||
                         (cfg.mode == MODE_SLAVE && !tag.main_locked);

  // Tag counting: the oscillator index wins over reference channel zero.
  always_comb begin
    osc_tag_counter_next = osc_tag_counter;
    ref_tag_counter_next = ref_tag_counter;
    if (tag.source_index == cfg.n_ref_channels) begin
      osc_tag_counter_next = osc_tag_counter + count_t'(1);
    end else if (tag.source_index == 4'd0) begin
      ref_tag_counter_next = ref_tag_counter + count_t'(1);
    end
  end

  // One sequencer transition per tag event.
  always_comb begin
    phase_next           = phase;
    settle_deadline_next = settle_deadline;
    delock_counter_next  = delock_counter;
    clr    = 1'b0;
    sx     = 1'b0;
    sh     = 1'b0;
    sm     = 1'b0;
    st     = 1'b0;
    tagger = TAGGER_KEEP;
    ev     = STATUS_NONE;
    unique case (phase)
      PH_CLEAR: begin
        clr                  = 1'b1;
        tagger               = TAGGER_ENABLE;
        settle_deadline_next = tag.now_ticks + cfg.settle_ticks;
        phase_next           = PH_WAIT_CLEAR;
      end
      PH_WAIT_CLEAR: begin
        if (deadline_diff[31]) begin
          phase_next = (cfg.mode == MODE_GM) ? PH_START_EXT : PH_START_HELPER;
        end
      end
      PH_START_EXT: begin
        tagger     = TAGGER_DISABLE;
        sx         = 1'b1;
        phase_next = PH_WAIT_EXT;
      end
      PH_WAIT_EXT: begin
        if (tag.ext_locked) begin
          st         = 1'b1;
          ev         = STATUS_LOCKED;
          phase_next = PH_READY;
        end
      end
      PH_START_HELPER: begin
        sh         = 1'b1;
        phase_next = PH_WAIT_HELPER;
      end
      PH_WAIT_HELPER: begin
        if (tag.helper_locked && tag.helper_lock_changed) begin
          if (cfg.mode == MODE_SLAVE) begin
            phase_next = PH_START_MAIN;
          end else begin
            st         = 1'b1;
            ev         = STATUS_LOCKED;
            phase_next = PH_READY;
          end
        end
      end
      PH_START_MAIN: begin
        sm         = 1'b1;
        phase_next = PH_WAIT_MAIN;
      end
      PH_WAIT_MAIN: begin
        if (tag.main_locked) begin
          st         = 1'b1;
          ev         = STATUS_LOCKED;
          phase_next = PH_READY;
        end
      end
      PH_READY: begin
        if (delocked) begin
          delock_counter_next = delock_counter + count_t'(1);
          ev                  = STATUS_CLEAR;
          phase_next          = PH_CLEAR;
        end
      end
      default: ;
    endcase
  end

  // State update; a mode write restarts the sequence and clears counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_DISABLED;
      settle_deadline <= 32'd0;
      delock_counter  <= '0;
      osc_tag_counter <= '0;
      ref_tag_counter <= '0;
    end else if (cfg.restart) begin
      phase           <= (cfg.restart_mode == MODE_DISABLED) ? PH_DISABLED : PH_CLEAR;
      delock_counter  <= '0;
      osc_tag_counter <= '0;
      ref_tag_counter <= '0;
    end else if (accept) begin
      phase           <= phase_next;
      settle_deadline <= settle_deadline_next;
      delock_counter  <= delock_counter_next;
      osc_tag_counter <= osc_tag_counter_next;
      ref_tag_counter <= ref_tag_counter_next;
    end
  end

  // Result of this event, taken by the output buffer on a transfer.
  assign res.sequence_phase = phase_next;
  assign res.clear_dacs     = clr;
  assign res.main_dac_mid   = dac_sum[16:1];
  assign res.tagger_ctrl    = tagger;
  assign res.start_ext      = sx;
  assign res.start_helper   = sh;
  assign res.start_main     = sm;
  assign res.start_trackers = st;
  assign res.status_event   = ev;
  assign res.delock_total   = count_to_32(delock_counter_next);
  assign res.osc_tag_total  = count_to_32(osc_tag_counter_next);
  assign res.ref_tag_total  = count_to_32(ref_tag_counter_next);

endmodule

FILE: hdl/pss_obuf.sv
// Two-entry result buffer that decouples the input and output transfers.
module pss_obuf (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  pss_pkg::res_item_t  push_data,
  output logic                full,
  output logic                res_valid,
  input  logic                res_stall,
  output pss_pkg::res_item_t  res
);
  import pss_pkg::*;

  res_item_t   entry [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        pop;

  assign pop       = res_valid && !res_stall;
  assign res_valid = (count != 2'd0);
  assign full      = (count == 2'd2);
  assign res       = entry[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

FILE: hdl/pll_startup_sequencer.sv
// Top level of the PLL start-up and supervision sequencer.
//
//   Channel  Signals                         Direction  Transfer when
//   tag      tag_valid, tag_stall, tag        in         tag_valid && !tag_stall
//   res      res_valid, res_stall, res        out        res_valid && !res_stall
//   cfg      cfg_valid, cfg_ready, cfg_index,  in         cfg_valid && cfg_ready
//            cfg_data
//
// One tag event is taken per cycle while tag_stall is low; its result is ready
// in the output buffer on the next cycle.
// The two-entry output buffer sets the rate: tag_stall rises only when both
// entries hold results that the output side has not yet taken.
// Reset clears the phase to disabled, zeroes counters and loads register defaults.
// Configuration writes are always taken; a mode write restarts the sequence
// at the same edge.
module pll_startup_sequencer (
  input  logic                clk,
  input  logic                rst,
  input  logic                tag_valid,
  output logic                tag_stall,
  input  pss_pkg::tag_item_t  tag,
  output logic                res_valid,
  input  logic                res_stall,
  output pss_pkg::res_item_t  res,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data
);
  import pss_pkg::*;

  cfg_t       cfg;
  res_item_t  core_res;
  logic [3:0] phase;
  logic       accept;
  logic       full;

  assign cfg_ready = 1'b1;
  assign tag_stall = full;
  assign accept    = tag_valid && !tag_stall;

  // Register file.
  pss_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Sequencer and counters.
  pss_core u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .accept (accept),
    .tag    (tag),
    .res    (core_res),
    .phase  (phase)
  );

  // Result buffer.
  pss_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (core_res),
    .full      (full),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  // An accepted event with no output transfer leaves a result pending.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (accept && !(res_valid && !res_stall)) |=> res_valid)
    else $error("accepted tag event left no pending result");

  // A mode write sends the sequencer to disabled or to clear.
  a_mode_restart: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready && cfg_index == CFG_MODE) |=>
      ((phase == PH_DISABLED) == ($past(cfg_data[1:0]) == MODE_DISABLED)) &&
      (phase == PH_DISABLED || phase == PH_CLEAR))
    else $error("mode write did not restart the sequencer");

  // A clear pulse always comes with tagger enable and the wait-clear phase.
  a_clear_result: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.clear_dacs) |->
      (res.sequence_phase == PH_WAIT_CLEAR && res.tagger_ctrl == TAGGER_ENABLE))
    else $error("clear pulse without matching phase and tagger command");

endmodule

FILE: sim/testbench.sv
// Self-checking testbench for the PLL start-up sequencer with a built-in predictor.
module testbench;
  import pss_pkg::*;

  // Register indexes past the end of the register list.
  localparam logic [2:0] CFG_SPARE_A = 3'd6;
  localparam logic [2:0] CFG_SPARE_B = 3'd7;
  localparam int STUCK_LIMIT = 2000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        tag_valid = 1'b0;
  logic        tag_stall;
  tag_item_t   tag = '0;
  logic        res_valid;
  logic        res_stall = 1'b0;
  res_item_t   res;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // Register copy and sequencer state of the predictor.
  logic [1:0]  cur_mode;
  logic [3:0]  cur_nref;
  logic [31:0] cur_settle;
  logic [15:0] cur_helper_max;
  logic [15:0] cur_dac_min;
  logic [15:0] cur_dac_max;
  logic [3:0]  seq_phase;
  logic [31:0] settle_deadline;
  count_t      delock_tally;
  count_t      osc_count;
  count_t      ref_tally;

  tag_item_t   tags_to_send[$];
  res_item_t   results_due[$];
  res_item_t   oldest_due;
  res_item_t   next_due;

  // Stimulus timer and idling controls.
  logic [31:0] stim_clock = '0;
  int          idle_odds = 8;
  bit          no_idling = 1'b0;
  int          send_gap = 0;
  int          stall_left = 0;
  int          stuck_cycles = 0;
  bit          failed = 1'b0;
  int          n_tags = 0;
  int          n_results = 0;
  int          n_writes = 0;
  int          n_ready = 0;
  int          n_delock = 0;

  pll_startup_sequencer DUT (
    .clk       (clk),
    .rst       (rst),
    .tag_valid (tag_valid),
    .tag_stall (tag_stall),
    .tag       (tag),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Predictor state after reset.
  function automatic void reset_model();
    cur_mode        = MODE_DISABLED;
    cur_nref        = 4'd1;
    cur_settle      = SETTLE_TICKS_RESET;
    cur_helper_max  = 16'hFFFF;
    cur_dac_min     = 16'h0000;
    cur_dac_max     = 16'hFFFF;
    seq_phase       = PH_DISABLED;
    settle_deadline = '0;
    delock_tally    = '0;
    osc_count       = '0;
    ref_tally       = '0;
  endfunction

  // A register write; a mode write restarts the sequence and clears the counters.
  function automatic void take_register(logic [2:0] idx, logic [31:0] val);
    case (idx)
      CFG_MODE: begin
        cur_mode     = val[1:0];
        delock_tally = '0;
        osc_count    = '0;
        ref_tally    = '0;
        seq_phase    = (val[1:0] == MODE_DISABLED) ? PH_DISABLED : PH_CLEAR;
      end
      CFG_N_REF_CHANNELS: cur_nref       = val[3:0];
      CFG_SETTLE_TICKS:   cur_settle     = val;
      CFG_HELPER_DAC_MAX: cur_helper_max = val[15:0];
      CFG_MAIN_DAC_MIN:   cur_dac_min    = val[15:0];
      CFG_MAIN_DAC_MAX:   cur_dac_max    = val[15:0];
      default: ;
    endcase
  endfunction

  // Counts the tag, then makes at most one sequencer transition.
  function automatic res_item_t advance_sequencer(tag_item_t t);
    res_item_t   r;
    logic [16:0] dac_sum;
    logic [31:0] margin;
    r = '0;
    dac_sum = {1'b0, cur_dac_min} + {1'b0, cur_dac_max};
    if (t.source_index == cur_nref)
      osc_count = osc_count + count_t'(1);
    else if (t.source_index == 4'd0)
      ref_tally = ref_tally + count_t'(1);

    case (seq_phase)
      PH_CLEAR: begin
        r.clear_dacs    = 1'b1;
        r.tagger_ctrl   = TAGGER_ENABLE;
        settle_deadline = t.now_ticks + cur_settle;
        seq_phase       = PH_WAIT_CLEAR;
      end
      PH_WAIT_CLEAR: begin
        // The wait ends once the timer is strictly past the deadline, modulo wrap.
        margin = settle_deadline - t.now_ticks;
        if (margin[31])
          seq_phase = (cur_mode == MODE_GM) ? PH_START_EXT : PH_START_HELPER;
      end
      PH_START_EXT: begin
        r.tagger_ctrl = TAGGER_DISABLE;
        r.start_ext   = 1'b1;
        seq_phase     = PH_WAIT_EXT;
      end
      PH_WAIT_EXT: begin
        if (t.ext_locked) begin
          r.start_trackers = 1'b1;
          r.status_event   = STATUS_LOCKED;
          seq_phase        = PH_READY;
        end
      end
      PH_START_HELPER: begin
        r.start_helper = 1'b1;
        seq_phase      = PH_WAIT_HELPER;
      end
      PH_WAIT_HELPER: begin
        if (t.helper_locked && t.helper_lock_changed) begin
          if (cur_mode == MODE_SLAVE) begin
            seq_phase = PH_START_MAIN;
          end else begin
            r.start_trackers = 1'b1;
            r.status_event   = STATUS_LOCKED;
            seq_phase        = PH_READY;
          end
        end
      end
      PH_START_MAIN: begin
        r.start_main = 1'b1;
        seq_phase    = PH_WAIT_MAIN;
      end
      PH_WAIT_MAIN: begin
        if (t.main_locked) begin
          r.start_trackers = 1'b1;
          r.status_event   = STATUS_LOCKED;
          seq_phase        = PH_READY;
        end
      end
      PH_READY: begin
        if ((cur_mode == MODE_GM && !t.ext_locked) || !t.helper_locked ||
            (cur_mode == MODE_SLAVE && !t.main_locked)) begin
          delock_tally   = delock_tally + count_t'(1);
          r.status_event = STATUS_CLEAR;
          seq_phase      = PH_CLEAR;
        end
      end
      default: ;
    endcase

    r.sequence_phase = seq_phase;
    r.main_dac_mid   = dac_sum[16:1];
    r.delock_total   = 32'(delock_tally);
    r.osc_tag_total  = 32'(osc_count);
    r.ref_tag_total  = 32'(ref_tally);
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      failed = 1'b1;
    end
  endtask

  function automatic tag_item_t mk(logic [3:0] src, logic [31:0] now, logic hl, logic hc,
                                   logic ml, logic el);
    tag_item_t t;
    t.source_index        = src;
    t.now_ticks           = now;
    t.helper_locked       = hl;
    t.helper_lock_changed = hc;
    t.main_locked         = ml;
    t.ext_locked          = el;
    return t;
  endfunction

  // Random tag event: sources lean toward reference zero and the oscillator, the
  // timer mostly runs forward, and locks hold with the given percentage.
  function automatic tag_item_t random_tag(logic [3:0] osc_src, int lock_pct);
    tag_item_t t;
    case ($urandom_range(0, 2))
      0:       t.source_index = 4'd0;
      1:       t.source_index = osc_src;
      default: t.source_index = 4'($urandom_range(0, 15));
    endcase
    if ($urandom_range(0, 19) == 0)
      stim_clock = $urandom;
    else
      stim_clock = stim_clock + $urandom_range(0, 8);
    t.now_ticks           = stim_clock;
    t.helper_locked       = ($urandom_range(1, 100) <= lock_pct);
    t.helper_lock_changed = 1'($urandom_range(0, 1));
    t.main_locked         = ($urandom_range(1, 100) <= lock_pct);
    t.ext_locked          = ($urandom_range(1, 100) <= lock_pct);
    return t;
  endfunction

  function automatic logic [15:0] dac_value();
    case ($urandom_range(0, 3))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // One register write; the caller is at a rising edge and lowers valid afterwards.
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Writes every register, mode last so that the restart sees the new settings.
  task automatic apply_settings(logic [1:0] m, logic [3:0] nref, logic [31:0] settle,
                                logic [15:0] hmax, logic [15:0] dmin, logic [15:0] dmax,
                                bit spare);
    @(posedge clk);
    write_reg(CFG_N_REF_CHANNELS, {28'd0, nref});
    write_reg(CFG_SETTLE_TICKS, settle);
    write_reg(CFG_HELPER_DAC_MAX, {16'd0, hmax});
    write_reg(CFG_MAIN_DAC_MIN, {16'd0, dmin});
    write_reg(CFG_MAIN_DAC_MAX, {16'd0, dmax});
    if (spare) begin
      write_reg(CFG_SPARE_A, $urandom);
      write_reg(CFG_SPARE_B, $urandom);
    end
    write_reg(CFG_MODE, {30'd0, m});
    cfg_valid <= 1'b0;
  endtask

  // Every tag event yields a result, so an empty result store means idle.
  task automatic wait_drained();
    do @(negedge clk);
    while (tags_to_send.size() != 0 || tag_valid || results_due.size() != 0);
    repeat (2) @(posedge clk);
  endtask

  // Tag driver: holds the payload while stalled, inserts idle bursts between transfers.
  always @(posedge clk) begin
    if (rst) begin
      tag_valid <= 1'b0;
      send_gap = 0;
    end else if (!tag_valid || !tag_stall) begin
      if (send_gap > 0 && !no_idling) begin
        send_gap--;
        tag_valid <= 1'b0;
      end else if (!no_idling && $urandom_range(1, idle_odds) == 1) begin
        send_gap = $urandom_range(0, 6);
        tag_valid <= 1'b0;
      end else if (tags_to_send.size() != 0) begin
        tag       <= tags_to_send.pop_front();
        tag_valid <= 1'b1;
      end else begin
        tag_valid <= 1'b0;
      end
    end
  end

  // Result side stalls in bursts.
  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0 && !no_idling) begin
      stall_left--;
      res_stall <= 1'b1;
    end else if (!no_idling && $urandom_range(1, idle_odds) == 1) begin
      stall_left = $urandom_range(0, 6);
      res_stall <= 1'b1;
    end else begin
      res_stall <= 1'b0;
    end
  end

  // Monitor: tracks register writes, predicts each tag transfer, checks each result.
  always @(posedge clk) begin
    if (rst) begin
      reset_model();
      results_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        take_register(cfg_index, cfg_data);
        n_writes++;
      end
      if (res_valid && !res_stall) begin
        n_results++;
        if (results_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, res);
          failed = 1'b1;
        end else begin
          oldest_due = results_due.pop_front();
          check_field("sequence_phase", oldest_due.sequence_phase, res.sequence_phase);
          check_field("clear_dacs", oldest_due.clear_dacs, res.clear_dacs);
          check_field("main_dac_mid", oldest_due.main_dac_mid, res.main_dac_mid);
          check_field("tagger_ctrl", oldest_due.tagger_ctrl, res.tagger_ctrl);
          check_field("start_ext", oldest_due.start_ext, res.start_ext);
          check_field("start_helper", oldest_due.start_helper, res.start_helper);
          check_field("start_main", oldest_due.start_main, res.start_main);
          check_field("start_trackers", oldest_due.start_trackers, res.start_trackers);
          check_field("status_event", oldest_due.status_event, res.status_event);
          check_field("delock_total", oldest_due.delock_total, res.delock_total);
          check_field("osc_tag_total", oldest_due.osc_tag_total, res.osc_tag_total);
          check_field("ref_tag_total", oldest_due.ref_tag_total, res.ref_tag_total);
        end
      end
      if (tag_valid && !tag_stall) begin
        next_due = advance_sequencer(tag);
        results_due.push_back(next_due);
        n_tags++;
        if (next_due.status_event == STATUS_LOCKED)
          n_ready++;
        else if (next_due.status_event == STATUS_CLEAR)
          n_delock++;
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (rst || (tag_valid && !tag_stall) || (res_valid && !res_stall) ||
        (cfg_valid && cfg_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, stuck_cycles);
      $display("Verification failed");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    int          ph;
    int          lock_pct;
    logic [1:0]  m;
    logic [3:0]  nref;
    logic [31:0] settle;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Register defaults: sequencer stays disabled while tags are counted.
    tags_to_send.push_back(mk(4'd0, 32'd0, 1'b0, 1'b0, 1'b0, 1'b0));
    tags_to_send.push_back(mk(4'd1, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 1'b1));
    tags_to_send.push_back(mk(4'd15, 32'd7, 1'b0, 1'b1, 1'b0, 1'b1));
    tags_to_send.push_back(mk(4'd1, 32'd8, 1'b1, 1'b0, 1'b1, 1'b0));
    wait_drained();

    // Grandmaster path: deadline wraps past zero, equal time is not yet past it.
    apply_settings(MODE_GM, 4'd2, 32'd5, 16'h0000, 16'h0000, 16'hFFFF, 1'b1);
    tags_to_send.push_back(mk(4'd0, 32'hFFFF_FFFE, 1'b1, 1'b1, 1'b1, 1'b1));
    tags_to_send.push_back(mk(4'd2, 32'd2, 1'b1, 1'b1, 1'b1, 1'b1));
    tags_to_send.push_back(mk(4'd15, 32'd3, 1'b1, 1'b1, 1'b1, 1'b1));
    tags_to_send.push_back(mk(4'd0, 32'd4, 1'b1, 1'b1, 1'b1, 1'b1));
    tags_to_send.push_back(mk(4'd1, 32'd5, 1'b1, 1'b1, 1'b1, 1'b1));
    tags_to_send.push_back(mk(4'd0, 32'd6, 1'b1, 1'b1, 1'b1, 1'b0));
    tags_to_send.push_back(mk(4'd2, 32'd7, 1'b1, 1'b1, 1'b1, 1'b1));
    tags_to_send.push_back(mk(4'd0, 32'd8, 1'b1, 1'b0, 1'b0, 1'b1));
    tags_to_send.push_back(mk(4'd2, 32'd9, 1'b1, 1'b1, 1'b1, 1'b0));
    tags_to_send.push_back(mk(4'd0, 32'h7FFF_FFFF, 1'b1, 1'b1, 1'b1, 1'b1));
    wait_drained();

    // Slave path with oscillator index zero and the longest settling wait.
    apply_settings(MODE_SLAVE, 4'd0, 32'hFFFF_FFFF, 16'hFFFF, 16'h0000, 16'h0000, 1'b0);
    tags_to_send.push_back(mk(4'd0, 32'd100, 1'b1, 1'b1, 1'b1, 1'b1));
    tags_to_send.push_back(mk(4'd5, 32'd100, 1'b1, 1'b1, 1'b1, 1'b1));
    tags_to_send.push_back(mk(4'd0, 32'd101, 1'b1, 1'b1, 1'b1, 1'b1));
    tags_to_send.push_back(mk(4'd0, 32'd102, 1'b1, 1'b0, 1'b1, 1'b1));
    tags_to_send.push_back(mk(4'd9, 32'd103, 1'b0, 1'b1, 1'b1, 1'b1));
    tags_to_send.push_back(mk(4'd0, 32'd104, 1'b1, 1'b1, 1'b0, 1'b0));
    tags_to_send.push_back(mk(4'd0, 32'd105, 1'b1, 1'b0, 1'b0, 1'b0));
    tags_to_send.push_back(mk(4'd3, 32'd106, 1'b1, 1'b0, 1'b0, 1'b1));
    tags_to_send.push_back(mk(4'd0, 32'd107, 1'b1, 1'b0, 1'b1, 1'b0));
    tags_to_send.push_back(mk(4'd0, 32'd108, 1'b1, 1'b1, 1'b0, 1'b1));
    wait_drained();

    // Free-running master: half-range deadline and a full-scale DAC sum.
    apply_settings(MODE_MASTER, 4'd15, 32'h8000_0000, 16'h1234, 16'hFFFF, 16'hFFFF, 1'b1);
    tags_to_send.push_back(mk(4'd15, 32'd0, 1'b1, 1'b1, 1'b1, 1'b1));
    tags_to_send.push_back(mk(4'd0, 32'h8000_0000, 1'b1, 1'b1, 1'b1, 1'b1));
    tags_to_send.push_back(mk(4'd15, 32'h8000_0001, 1'b1, 1'b1, 1'b1, 1'b1));
    tags_to_send.push_back(mk(4'd0, 32'h8000_0002, 1'b1, 1'b1, 1'b0, 1'b0));
    tags_to_send.push_back(mk(4'd15, 32'h8000_0003, 1'b1, 1'b1, 1'b0, 1'b0));
    tags_to_send.push_back(mk(4'd0, 32'h8000_0004, 1'b0, 1'b0, 1'b1, 1'b1));
    wait_drained();

    // Random settings and sequences; the final phase runs without idling.
    for (ph = 0; ph < 11; ph++) begin
      no_idling = (ph == 10);
      idle_odds = $urandom_range(3, 20);
      m = ($urandom_range(0, 9) == 0) ? MODE_DISABLED : 2'($urandom_range(1, 3));
      nref = 4'($urandom_range(0, 15));
      case ($urandom_range(0, 9))
        0:       settle = 32'd1;
        1:       settle = 32'hFFFF_FFFF;
        2:       settle = $urandom;
        default: settle = $urandom_range(1, 40);
      endcase
      apply_settings(m, nref, settle, dac_value(), dac_value(), dac_value(),
                     $urandom_range(0, 3) == 0);
      lock_pct = $urandom_range(70, 97);
      repeat (60) tags_to_send.push_back(random_tag(nref, lock_pct));
      wait_drained();
    end

    repeat (4) @(posedge clk);
    $display("Sent %0d tag events, checked %0d results, took %0d register writes.",
             n_tags, n_results, n_writes);
    $display("The sequencer reached ready %0d times and lost lock %0d times.",
             n_ready, n_delock);
    if (!failed)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
